/* rtl/core/ansi_escape_sequence_parser_top_macros.svh */
// assertion macros for the escape sequence parser checker
// expects clk_i and rst_ni in the scope of each use
`ifndef ANSI_ESCAPE_SEQUENCE_PARSER_TOP_MACROS_SVH
`define ANSI_ESCAPE_SEQUENCE_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define AESP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AESP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/aesp_pkg.sv */
// types, constants and lookup tables of the escape sequence parser
// no dependencies
`timescale 1ns / 1ps

package aesp_pkg;

  localparam int MaxParams  = 16;
  localparam int ParamWidth = 16;
  localparam int IdxW       = (MaxParams > 1) ? $clog2(MaxParams) : 1;
  localparam int CntW       = $clog2(MaxParams + 1);
  localparam int ActW       = 6;

  typedef logic [7:0]            byte_t;
  typedef logic [ActW-1:0]       act_t;
  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [CntW-1:0]       cnt_t;
  typedef logic [ParamWidth-1:0] param_t;

  typedef enum logic [2:0] {
    GRP_GROUND = 3'd0,
    GRP_C0     = 3'd1,
    GRP_ESC    = 3'd2,
    GRP_CSI    = 3'd3,
    GRP_CSI_P  = 3'd4,
    GRP_CSI_F  = 3'd5
  } group_e;

  typedef enum logic [1:0] {
    ST_REJECT  = 2'd0,
    ST_PENDING = 2'd1,
    ST_ACTION  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_EMIT = 2'd2
  } ctrl_state_e;

  localparam byte_t CHR_ESC   = 8'h1B;
  localparam byte_t CHR_SPACE = 8'h20;
  localparam byte_t CHR_DEL   = 8'h7F;
  localparam byte_t CHR_CSI   = 8'h9B;
  localparam byte_t CHR_0     = 8'h30;
  localparam byte_t CHR_9     = 8'h39;
  localparam byte_t CHR_SEMI  = 8'h3B;
  localparam byte_t CHR_LBRK  = 8'h5B;
  localparam byte_t CHR_S     = 8'h73;
  localparam byte_t CHR_U     = 8'h75;

  localparam act_t ACT_CHAR    = 6'd0;
  localparam act_t ACT_NUL     = 6'd1;
  localparam act_t ACT_ENQ     = 6'd6;
  localparam act_t ACT_BEL     = 6'd8;
  localparam act_t ACT_BS      = 6'd9;
  localparam act_t ACT_HT      = 6'd10;
  localparam act_t ACT_LF      = 6'd11;
  localparam act_t ACT_VT      = 6'd12;
  localparam act_t ACT_FF      = 6'd13;
  localparam act_t ACT_CR      = 6'd14;
  localparam act_t ACT_SO      = 6'd15;
  localparam act_t ACT_SI      = 6'd16;
  localparam act_t ACT_DC1     = 6'd18;
  localparam act_t ACT_DC2     = 6'd19;
  localparam act_t ACT_DC3     = 6'd20;
  localparam act_t ACT_IND     = 6'd22;
  localparam act_t ACT_NEL     = 6'd23;
  localparam act_t ACT_HTS     = 6'd24;
  localparam act_t ACT_RI      = 6'd25;
  localparam act_t ACT_SS2     = 6'd26;
  localparam act_t ACT_SS3     = 6'd27;
  localparam act_t ACT_DCS     = 6'd28;
  localparam act_t ACT_SOS     = 6'd29;
  localparam act_t ACT_PM      = 6'd30;
  localparam act_t ACT_APC     = 6'd31;
  localparam act_t ACT_SAVE    = 6'd32;
  localparam act_t ACT_RESTORE = 6'd33;
  localparam act_t ACT_CUU     = 6'd34;
  localparam act_t ACT_CUD     = 6'd35;
  localparam act_t ACT_CUF     = 6'd36;
  localparam act_t ACT_CUB     = 6'd37;
  localparam act_t ACT_CUP     = 6'd38;
  localparam act_t ACT_ED      = 6'd41;
  localparam act_t ACT_EL      = 6'd42;
  localparam act_t ACT_SGR     = 6'd43;
  localparam act_t ACT_DECSTBM = 6'd44;
  localparam act_t ACT_RM      = 6'd46;
  localparam act_t ACT_SM      = 6'd47;

  typedef struct packed {
    logic hit;
    act_t code;
  } act_lookup_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_single;
    logic rd_first;
    logic rd_next;
    logic load_param;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic multi;
    logic k_last;
  } dp_status_t;

  function automatic act_lookup_t hit_of(act_t code);
    act_lookup_t r;
    r.hit  = 1'b1;
    r.code = code;
    return r;
  endfunction

  function automatic act_lookup_t c1_lookup(byte_t b);
    act_lookup_t r;
    r = '0;
    unique case (b)
      8'h84:   r = hit_of(ACT_IND);
      8'h85:   r = hit_of(ACT_NEL);
      8'h88:   r = hit_of(ACT_HTS);
      8'h8D:   r = hit_of(ACT_RI);
      8'h8E:   r = hit_of(ACT_SS2);
      8'h8F:   r = hit_of(ACT_SS3);
      8'h90:   r = hit_of(ACT_DCS);
      8'h98:   r = hit_of(ACT_SOS);
      8'h9E:   r = hit_of(ACT_PM);
      8'h9F:   r = hit_of(ACT_APC);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic act_lookup_t c0_lookup(byte_t b);
    act_lookup_t r;
    r = '0;
    unique case (b)
      8'h00:   r = hit_of(ACT_NUL);
      8'h05:   r = hit_of(ACT_ENQ);
      8'h07:   r = hit_of(ACT_BEL);
      8'h08:   r = hit_of(ACT_BS);
      8'h09:   r = hit_of(ACT_HT);
      8'h0A:   r = hit_of(ACT_LF);
      8'h0B:   r = hit_of(ACT_VT);
      8'h0C:   r = hit_of(ACT_FF);
      8'h0D:   r = hit_of(ACT_CR);
      8'h0E:   r = hit_of(ACT_SO);
      8'h0F:   r = hit_of(ACT_SI);
      8'h11:   r = hit_of(ACT_DC1);
      8'h12:   r = hit_of(ACT_DC2);
      8'h13:   r = hit_of(ACT_DC3);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic act_lookup_t esc_lookup(byte_t b);
    act_lookup_t r;
    r = '0;
    unique case (b)
      8'h44:   r = hit_of(ACT_IND);
      8'h45:   r = hit_of(ACT_NEL);
      8'h48:   r = hit_of(ACT_HTS);
      8'h4D:   r = hit_of(ACT_RI);
      8'h4E:   r = hit_of(ACT_SS2);
      8'h4F:   r = hit_of(ACT_SS3);
      8'h50:   r = hit_of(ACT_DCS);
      8'h58:   r = hit_of(ACT_SOS);
      8'h5E:   r = hit_of(ACT_PM);
      8'h5F:   r = hit_of(ACT_APC);
      8'h37:   r = hit_of(ACT_SAVE);
      8'h38:   r = hit_of(ACT_RESTORE);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic act_lookup_t final_lookup(byte_t b);
    act_lookup_t r;
    r = '0;
    unique case (b)
      8'h41:   r = hit_of(ACT_CUU);
      8'h42:   r = hit_of(ACT_CUD);
      8'h43:   r = hit_of(ACT_CUF);
      8'h44:   r = hit_of(ACT_CUB);
      8'h48:   r = hit_of(ACT_CUP);
      8'h66:   r = hit_of(ACT_CUP);
      8'h4A:   r = hit_of(ACT_ED);
      8'h4B:   r = hit_of(ACT_EL);
      8'h6D:   r = hit_of(ACT_SGR);
      8'h72:   r = hit_of(ACT_DECSTBM);
      8'h6C:   r = hit_of(ACT_RM);
      8'h68:   r = hit_of(ACT_SM);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/aesp_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module aesp_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                             clk_i,
  input  logic                                             we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]     waddr_i,
  input  logic [Width-1:0]                                 wdata_i,
  input  logic                                             re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]     raddr_i,
  output logic [Width-1:0]                                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/aesp_datapath.sv */
// parser datapath: group, parameter collection, parameter ram, result register
// depends on aesp_pkg and aesp_ram
`timescale 1ns / 1ps

module aesp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aesp_pkg::byte_t     in_byte_i,
  input  logic                out_ready_i,
  input  aesp_pkg::dp_cmd_t   cmd_i,
  output aesp_pkg::dp_status_t stat_o,
  output logic                out_valid_o,
  output logic [1:0]          status_o,
  output aesp_pkg::act_t      action_o,
  output aesp_pkg::idx_t      param_index_o,
  output aesp_pkg::param_t    param_value_o,
  output aesp_pkg::cnt_t      param_count_o,
  output logic                last_o
);
  import aesp_pkg::*;

  localparam int WideW = ParamWidth + 4;

  byte_t   byte_q;
  group_e  group_q, group_d;
  cnt_t    count_q, count_d;
  logic    ovf_q, ovf_d;
  param_t  acc_q, acc_d;
  act_t    act_q;
  idx_t    k_q;

  cnt_t    eff_cnt;
  logic    eff_ovf;
  status_e res_status;
  act_t    res_act;
  group_e  next_grp;
  logic    digit_op, semi_op, is_digit, is_char;
  logic    we;
  idx_t    waddr;
  param_t  wdata;
  logic    [WideW-1:0] wide;
  param_t  acc_sat;
  logic    [3:0] dval;
  act_lookup_t c0_l, c1_l, esc_l, fin_l;
  logic    re;
  idx_t    raddr;
  param_t  rdata;

  logic    out_valid_q;
  status_e out_status_q;
  act_t    out_act_q;
  idx_t    out_idx_q;
  param_t  out_val_q;
  cnt_t    out_cnt_q;
  logic    out_last_q;

  always_comb begin
    c0_l     = c0_lookup(byte_q);
    c1_l     = c1_lookup(byte_q);
    esc_l    = esc_lookup(byte_q);
    fin_l    = final_lookup(byte_q);
    is_digit = (byte_q >= CHR_0) && (byte_q <= CHR_9);
    is_char  = (byte_q >= CHR_SPACE) && (byte_q != CHR_DEL);
    dval     = 4'(byte_q - CHR_0);
    eff_cnt  = (group_q == GRP_GROUND) ? '0 : count_q;
    eff_ovf  = (group_q == GRP_GROUND) ? 1'b0 : ovf_q;
    wide     = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + WideW'(dval);
    acc_sat  = (wide[WideW-1:ParamWidth] != '0) ? '1 : wide[ParamWidth-1:0];
  end

  // group decode
  always_comb begin
    res_status = ST_REJECT;
    res_act    = ACT_CHAR;
    next_grp   = GRP_GROUND;
    digit_op   = 1'b0;
    semi_op    = 1'b0;
    unique case (group_q)
      GRP_GROUND: begin
        if (byte_q < CHR_SPACE) begin
          if (byte_q == CHR_ESC) begin
            res_status = ST_PENDING;
            next_grp   = GRP_ESC;
          end else if (c0_l.hit) begin
            res_status = ST_ACTION;
            res_act    = c0_l.code;
          end
        end else if (c1_l.hit) begin
          res_status = ST_ACTION;
          res_act    = c1_l.code;
        end else if (byte_q == CHR_CSI) begin
          res_status = ST_PENDING;
          next_grp   = GRP_CSI;
        end else if (is_char) begin
          res_status = ST_ACTION;
          res_act    = ACT_CHAR;
        end
      end
      GRP_C0: begin
        if (byte_q == CHR_ESC) begin
          res_status = ST_PENDING;
          next_grp   = GRP_ESC;
        end else if (c0_l.hit) begin
          res_status = ST_ACTION;
          res_act    = c0_l.code;
        end
      end
      GRP_ESC: begin
        if (byte_q == CHR_LBRK) begin
          res_status = ST_PENDING;
          next_grp   = GRP_CSI;
        end else if (esc_l.hit) begin
          res_status = ST_ACTION;
          res_act    = esc_l.code;
        end
      end
      GRP_CSI: begin
        if (byte_q == CHR_S) begin
          res_status = ST_ACTION;
          res_act    = ACT_SAVE;
        end else if (byte_q == CHR_U) begin
          res_status = ST_ACTION;
          res_act    = ACT_RESTORE;
        end else if (is_digit) begin
          digit_op = 1'b1;
        end
      end
      GRP_CSI_P: begin
        if (is_digit) begin
          digit_op = 1'b1;
        end else if (byte_q == CHR_SEMI) begin
          semi_op = 1'b1;
        end else if (is_char && fin_l.hit) begin
          res_status = ST_ACTION;
          res_act    = fin_l.code;
        end
      end
      GRP_CSI_F: begin
        if (fin_l.hit) begin
          res_status = ST_ACTION;
          res_act    = fin_l.code;
        end
      end
      default: begin
        res_status = ST_REJECT;
      end
    endcase
    if (digit_op || semi_op) begin
      res_status = ST_PENDING;
      next_grp   = GRP_CSI_P;
    end
  end

  // parameter collection
  always_comb begin
    count_d = eff_cnt;
    ovf_d   = eff_ovf;
    acc_d   = acc_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    group_d = (res_status == ST_PENDING) ? next_grp : GRP_GROUND;
    if (res_status == ST_REJECT) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (digit_op && !eff_ovf) begin
      we = 1'b1;
      if (eff_cnt == '0) begin
        count_d = CntW'(1);
        acc_d   = ParamWidth'(dval);
        wdata   = ParamWidth'(dval);
      end else begin
        waddr   = idx_t'(eff_cnt - CntW'(1));
        acc_d   = acc_sat;
        wdata   = acc_sat;
      end
    end else if (semi_op && !eff_ovf) begin
      if (eff_cnt < CntW'(MaxParams)) begin
        we      = 1'b1;
        waddr   = eff_cnt[IdxW-1:0];
        count_d = eff_cnt + CntW'(1);
        acc_d   = '0;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= GRP_GROUND;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      group_q <= group_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= in_byte_i;
    end
    if (cmd_i.exec) begin
      acc_q <= acc_d;
      act_q <= res_act;
    end
    if (cmd_i.rd_first) begin
      k_q <= '0;
    end else if (cmd_i.rd_next) begin
      k_q <= k_q + idx_t'(1);
    end
  end

  assign re    = cmd_i.rd_first || cmd_i.rd_next;
  assign raddr = cmd_i.rd_first ? '0 : k_q + idx_t'(1);

  aesp_ram #(
    .Width (ParamWidth),
    .Depth (MaxParams)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (we && cmd_i.exec),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.load_param) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single) begin
      out_status_q <= res_status;
      out_act_q    <= (res_status == ST_ACTION) ? res_act : ACT_CHAR;
      out_idx_q    <= '0;
      out_val_q    <= '0;
      out_cnt_q    <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.load_param) begin
      out_status_q <= ST_ACTION;
      out_act_q    <= act_q;
      out_idx_q    <= k_q;
      out_val_q    <= rdata;
      out_cnt_q    <= count_q;
      out_last_q   <= stat_o.k_last;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.multi    = (res_status == ST_ACTION) && (eff_cnt != '0);
  assign stat_o.k_last   = (CntW'(k_q) + CntW'(1)) == count_q;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign action_o      = out_act_q;
  assign param_index_o = out_idx_q;
  assign param_value_o = out_val_q;
  assign param_count_o = out_cnt_q;
  assign last_o        = out_last_q;

endmodule

/* rtl/core/aesp_ctrl.sv */
// parser controller: request capture, decode step and parameter emission
// depends on aesp_pkg
`timescale 1ns / 1ps

module aesp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  aesp_pkg::dp_status_t stat_i,
  output aesp_pkg::dp_cmd_t    cmd_o
);
  import aesp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          state_d = stat_i.multi ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free && stat_i.k_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec        = 1'b1;
          cmd_o.rd_first    = stat_i.multi;
          cmd_o.load_single = !stat_i.multi;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_param = 1'b1;
          cmd_o.rd_next    = !stat_i.k_last;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* rtl/core/ansi_escape_sequence_parser_top.sv */
// top level of the terminal escape sequence parser
// depends on aesp_pkg, aesp_ctrl, aesp_datapath
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   in_byte_i
//   out      out  out_valid_o / out_ready_i status, action, param_index,
//                                           param_value, param_count, last
//
// a byte is first captured, then decoded with the state update in one step
// a csi final with n parameters gives n results, one ram read each
// the result register lets the next byte be captured while a result waits
// a full result register stalls the decode step and the emission
// reset returns to the ground group with no parameters held
`timescale 1ns / 1ps

module ansi_escape_sequence_parser_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output aesp_pkg::act_t   action_o,
  output aesp_pkg::idx_t   param_index_o,
  output aesp_pkg::param_t param_value_o,
  output aesp_pkg::cnt_t   param_count_o,
  output logic             last_o
);
  import aesp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  aesp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  aesp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .action_o      (action_o),
    .param_index_o (param_index_o),
    .param_value_o (param_value_o),
    .param_count_o (param_count_o),
    .last_o        (last_o)
  );

endmodule

/* rtl/core/aesp_checker.sv */
// port-level checks of the escape sequence parser, bound to the top level
// depends on aesp_pkg and the macro header
`timescale 1ns / 1ps
`include "ansi_escape_sequence_parser_top_macros.svh"

module aesp_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [7:0]       in_byte_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [1:0]       status_o,
  input aesp_pkg::act_t   action_o,
  input aesp_pkg::idx_t   param_index_o,
  input aesp_pkg::param_t param_value_o,
  input aesp_pkg::cnt_t   param_count_o,
  input logic             last_o
);
  import aesp_pkg::*;

  logic act_res;
  assign act_res = out_valid_o && (status_o == ST_ACTION);

  `AESP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(param_value_o) && $stable(last_o),
    "stalled result changed")

  `AESP_ASSERT_NOW(a_plain_result,
    out_valid_o && (status_o != ST_ACTION),
    last_o && (param_count_o == '0) && (action_o == ACT_CHAR) && (status_o != 2'd3),
    "pending or rejected result carries fields")

  `AESP_ASSERT_NOW(a_param_index, act_res && (param_count_o != '0),
    (CntW'(param_index_o) < param_count_o)
      && (last_o == ((CntW'(param_index_o) + CntW'(1)) == param_count_o)),
    "parameter index or last mark wrong")

  `AESP_ASSERT_NEXT(a_param_order,
    act_res && out_ready_i && !last_o && (param_count_o != '0),
    out_valid_o && (param_index_o == $past(param_index_o) + idx_t'(1))
      && (param_count_o == $past(param_count_o)),
    "parameter results out of order")

endmodule

bind ansi_escape_sequence_parser_top aesp_checker u_aesp_checker (.*);

/* dv/tb_top.sv */
// self-checking testbench for ansi_escape_sequence_parser_top
// scoreboard against an in-file parser model, randomized request and result idling
// depends on aesp_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_top;
  import aesp_pkg::*;

  localparam int HoldAt    = 200;
  localparam int HoldLen   = 100;
  localparam int StallMax  = 1000;
  localparam int TailWait  = 40;
  localparam int NumRandom = 300;
  localparam int MaxReport = 10;

  typedef struct packed {
    status_e status;
    act_t    action;
    idx_t    param_index;
    param_t  param_value;
    cnt_t    param_count;
    logic    last;
  } parse_result_t;

  typedef struct {
    byte_t data;
    bit    drain;
  } request_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  byte_t  in_byte_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  logic [1:0] status_o;
  act_t   action_o;
  idx_t   param_index_o;
  param_t param_value_o;
  cnt_t   param_count_o;
  logic   last_o;

  request_t      request_q[$];
  parse_result_t exp_results[$];

  group_e cur_group = GRP_GROUND;
  param_t param_store[MaxParams];
  int     param_cnt = 0;
  bit     param_ovf = 1'b0;

  int  in_count = 0;
  int  total_requests = 0;
  int  mismatches = 0;
  int  stall_run = 0;
  bit  in_taken = 1'b0;
  bit  drain_next = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  hold_armed = 1'b1;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  wire no_idle     = in_count >= total_requests - 40;
  wire hold_window = in_count >= HoldAt - 4 && in_count < HoldAt + 40;

  always #10 clk_i = ~clk_i;

  ansi_escape_sequence_parser_top DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .action_o,
    .param_index_o,
    .param_value_o,
    .param_count_o,
    .last_o
  );

  function automatic bit find_action(input group_e g, input byte_t b, output act_t a);
    a = '0;
    case (g)
      GRP_GROUND: case (b)
        8'h84: a = ACT_IND;
        8'h85: a = ACT_NEL;
        8'h88: a = ACT_HTS;
        8'h8D: a = ACT_RI;
        8'h8E: a = ACT_SS2;
        8'h8F: a = ACT_SS3;
        8'h90: a = ACT_DCS;
        8'h98: a = ACT_SOS;
        8'h9E: a = ACT_PM;
        8'h9F: a = ACT_APC;
        default: return 1'b0;
      endcase
      GRP_C0: case (b)
        8'h00: a = ACT_NUL;
        8'h05: a = ACT_ENQ;
        8'h07: a = ACT_BEL;
        8'h08: a = ACT_BS;
        8'h09: a = ACT_HT;
        8'h0A: a = ACT_LF;
        8'h0B: a = ACT_VT;
        8'h0C: a = ACT_FF;
        8'h0D: a = ACT_CR;
        8'h0E: a = ACT_SO;
        8'h0F: a = ACT_SI;
        8'h11: a = ACT_DC1;
        8'h12: a = ACT_DC2;
        8'h13: a = ACT_DC3;
        default: return 1'b0;
      endcase
      GRP_ESC: case (b)
        8'h44: a = ACT_IND;
        8'h45: a = ACT_NEL;
        8'h48: a = ACT_HTS;
        8'h4D: a = ACT_RI;
        8'h4E: a = ACT_SS2;
        8'h4F: a = ACT_SS3;
        8'h50: a = ACT_DCS;
        8'h58: a = ACT_SOS;
        8'h5E: a = ACT_PM;
        8'h5F: a = ACT_APC;
        8'h37: a = ACT_SAVE;
        8'h38: a = ACT_RESTORE;
        default: return 1'b0;
      endcase
      GRP_CSI_F: case (b)
        8'h41: a = ACT_CUU;
        8'h42: a = ACT_CUD;
        8'h43: a = ACT_CUF;
        8'h44: a = ACT_CUB;
        8'h48, 8'h66: a = ACT_CUP;
        8'h4A: a = ACT_ED;
        8'h4B: a = ACT_EL;
        8'h6D: a = ACT_SGR;
        8'h72: a = ACT_DECSTBM;
        8'h6C: a = ACT_RM;
        8'h68: a = ACT_SM;
        default: return 1'b0;
      endcase
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void push_expect(status_e s, act_t a, int k, param_t v, int n, bit l);
    parse_result_t r;
    r.status      = s;
    r.action      = a;
    r.param_index = idx_t'(k);
    r.param_value = v;
    r.param_count = cnt_t'(n);
    r.last        = l;
    exp_results.push_back(r);
  endfunction

  // walks the match groups for one byte and queues the results it causes
  function automatic void decode_byte(byte_t b);
    group_e g;
    group_e nxt;
    act_t   act;
    bit     hit;
    bit     pend;
    bit     more;
    int     v;
    g    = cur_group;
    nxt  = GRP_GROUND;
    act  = '0;
    hit  = 1'b0;
    pend = 1'b0;
    more = 1'b1;
    if (g == GRP_GROUND) begin
      param_cnt = 0;
      param_ovf = 1'b0;
    end
    while (more) begin
      more = 1'b0;
      case (g)
        GRP_GROUND: begin
          if (b < CHR_SPACE) begin
            g = GRP_C0;
            more = 1'b1;
          end else if (find_action(GRP_GROUND, b, act)) begin
            hit = 1'b1;
          end else if (b == CHR_CSI) begin
            pend = 1'b1;
            nxt = GRP_CSI;
          end else if (b != CHR_DEL) begin
            hit = 1'b1;
            act = ACT_CHAR;
          end
        end
        GRP_C0: begin
          if (b == CHR_ESC) begin
            pend = 1'b1;
            nxt = GRP_ESC;
          end else begin
            hit = find_action(GRP_C0, b, act);
          end
        end
        GRP_ESC: begin
          if (b == CHR_LBRK) begin
            pend = 1'b1;
            nxt = GRP_CSI;
          end else begin
            hit = find_action(GRP_ESC, b, act);
          end
        end
        GRP_CSI: begin
          if (b == CHR_S) begin
            hit = 1'b1;
            act = ACT_SAVE;
          end else if (b == CHR_U) begin
            hit = 1'b1;
            act = ACT_RESTORE;
          end else if (b >= CHR_0 && b <= CHR_9) begin
            g = GRP_CSI_P;
            more = 1'b1;
          end
        end
        GRP_CSI_P: begin
          if (b >= CHR_0 && b <= CHR_9) begin
            if (!param_ovf) begin
              if (param_cnt == 0) begin
                param_store[0] = param_t'(b - CHR_0);
                param_cnt = 1;
              end else begin
                v = int'(param_store[param_cnt-1]) * 10 + int'(b) - int'(CHR_0);
                param_store[param_cnt-1] = (v > int'({ParamWidth{1'b1}})) ? '1 : param_t'(v);
              end
            end
            pend = 1'b1;
            nxt = GRP_CSI_P;
          end else if (b == CHR_SEMI) begin
            if (!param_ovf) begin
              if (param_cnt < MaxParams) begin
                param_store[param_cnt] = '0;
                param_cnt++;
              end else begin
                param_ovf = 1'b1;
              end
            end
            pend = 1'b1;
            nxt = GRP_CSI_P;
          end else if (b >= CHR_SPACE && b != CHR_DEL) begin
            g = GRP_CSI_F;
            more = 1'b1;
          end
        end
        GRP_CSI_F: hit = find_action(GRP_CSI_F, b, act);
        default: ;
      endcase
    end
    if (hit) begin
      cur_group = GRP_GROUND;
      if (param_cnt == 0) begin
        push_expect(ST_ACTION, act, 0, '0, 0, 1'b1);
      end else begin
        for (int k = 0; k < param_cnt; k++)
          push_expect(ST_ACTION, act, k, param_store[k], param_cnt, k == param_cnt - 1);
      end
    end else if (pend) begin
      cur_group = nxt;
      push_expect(ST_PENDING, '0, 0, '0, 0, 1'b1);
    end else begin
      cur_group = GRP_GROUND;
      param_cnt = 0;
      param_ovf = 1'b0;
      push_expect(ST_REJECT, '0, 0, '0, 0, 1'b1);
    end
  endfunction

  function automatic void push_byte(byte_t b);
    request_t r;
    r.data  = b;
    r.drain = drain_next;
    drain_next = 1'b0;
    request_q.push_back(r);
  endfunction

  function automatic void push_intro();
    if ($urandom_range(0, 1)) begin
      push_byte(CHR_CSI);
    end else begin
      push_byte(CHR_ESC);
      push_byte(CHR_LBRK);
    end
  endfunction

  // request driver
  always @(negedge clk_i) begin
    logic  v_next;
    byte_t d_next;
    v_next = in_valid_i && !in_taken;
    d_next = in_byte_i;
    if (rst_ni && !v_next) begin
      if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
      if (tx_gap != 0) begin
        tx_gap--;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain && exp_results.size() != 0)) begin
        if (!tx_calm && !no_idle && !hold_window && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 10);
        end else begin
          d_next = request_q[0].data;
          request_q.delete(0);
          v_next = 1'b1;
        end
      end
    end
    in_valid_i <= v_next;
    in_byte_i  <= d_next;
  end

  // result receiver
  always @(negedge clk_i) begin
    logic r;
    r = 1'b0;
    if (rst_ni) begin
      if (hold_armed && in_count >= HoldAt) begin
        hold_armed = 1'b0;
        hold_left = HoldLen;
      end
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      if (hold_left != 0) begin
        hold_left--;
      end else if (no_idle || rx_calm) begin
        r = 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap--;
      end else if ($urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 10);
      end else begin
        r = 1'b1;
      end
    end
    out_ready_i <= r;
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk_i) begin
    parse_result_t got;
    parse_result_t want;
    bit out_taken;
    in_taken  = rst_ni && in_valid_i && in_ready_o;
    out_taken = rst_ni && out_valid_o === 1'b1 && out_ready_i;
    if (in_taken) begin
      decode_byte(in_byte_i);
      in_count++;
    end
    if (out_taken) begin
      got.status      = status_e'(status_o);
      got.action      = action_o;
      got.param_index = param_index_o;
      got.param_value = param_value_o;
      got.param_count = param_count_o;
      got.last        = last_o;
      if (exp_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $display("unexpected result: status %0d action %0d", got.status, got.action);
      end else begin
        want = exp_results.pop_front();
        if (got.status !== want.status || got.action !== want.action ||
            got.param_index !== want.param_index || got.param_value !== want.param_value ||
            got.param_count !== want.param_count || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MaxReport)
            $display({"mismatch: exp st %0d act %0d idx %0d val %0d cnt %0d last %0d,",
                      " got st %0d act %0d idx %0d val %0d cnt %0d last %0d"},
                     want.status, want.action, want.param_index, want.param_value,
                     want.param_count, want.last, got.status, got.action,
                     got.param_index, got.param_value, got.param_count, got.last);
        end
      end
    end
    if (in_taken || out_taken || !rst_ni) stall_run = 0;
    else stall_run++;
    if (stall_run >= StallMax) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    byte_t c1_set[10]    = '{8'h84, 8'h85, 8'h88, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h98, 8'h9E,
                             8'h9F};
    byte_t esc_set[12]   = '{8'h44, 8'h45, 8'h48, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h58, 8'h5E,
                             8'h5F, 8'h37, 8'h38};
    byte_t final_set[12] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h48, 8'h66, 8'h4A, 8'h4B, 8'h6D,
                             8'h72, 8'h6C, 8'h68};
    byte_t directed[25]  = '{8'h41, 8'h20, 8'hFF, CHR_DEL, 8'h00, 8'h10, 8'h11, 8'h84,
                             CHR_CSI, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, CHR_SEMI, 8'h48,
                             CHR_ESC, CHR_LBRK, CHR_S, CHR_ESC, 8'h5A, CHR_CSI, 8'h78,
                             CHR_CSI, 8'h31};
    int  kind;
    int  np;
    int  nd;
    bit  drained;
    drained = 1'b0;

    // printable, extremes, unlisted controls, saturation, ESC and CSI rejects
    foreach (directed[i]) push_byte(directed[i]);
    push_byte(8'h7A);

    while (request_q.size() < 26 + NumRandom) begin
      if (!drained && request_q.size() >= 120) begin
        drain_next = 1'b1;
        drained = 1'b1;
      end
      kind = $urandom_range(0, 19);
      if (kind <= 2) begin
        push_byte(byte_t'($urandom_range(8'h20, 8'hFF)));
      end else if (kind == 3) begin
        push_byte(byte_t'($urandom_range(0, 255)));
      end else if (kind <= 5) begin
        push_byte(byte_t'($urandom_range(0, 31)));
      end else if (kind == 6) begin
        push_byte(c1_set[$urandom_range(0, 9)]);
      end else if (kind <= 8) begin
        push_byte(CHR_ESC);
        if ($urandom_range(0, 3) == 0) push_byte(byte_t'($urandom_range(0, 255)));
        else push_byte(esc_set[$urandom_range(0, 11)]);
      end else if (kind <= 10) begin
        push_intro();
        push_byte($urandom_range(0, 1) ? CHR_S : CHR_U);
      end else if (kind <= 18) begin
        // csi with parameters, now and then past the parameter limit
        push_intro();
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
        for (int p = 0; p < np; p++) begin
          if (p != 0) push_byte(CHR_SEMI);
          if (np > 4) nd = $urandom_range(p == 0 ? 1 : 0, 2);
          else nd = $urandom_range(p == 0 ? 1 : 0, 6);
          for (int d = 0; d < nd; d++) push_byte(byte_t'($urandom_range(CHR_0, CHR_9)));
          if ($urandom_range(0, 15) == 0) push_byte(byte_t'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0) push_byte(byte_t'($urandom_range(0, 255)));
        else push_byte(final_set[$urandom_range(0, 11)]);
      end else begin
        push_intro();
        push_byte(byte_t'($urandom_range(0, 255)));
      end
    end
    total_requests = request_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (in_count < total_requests || exp_results.size() != 0) @(negedge clk_i);
    repeat (TailWait) @(negedge clk_i);
    if (exp_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/aesp_pkg.sv
rtl/core/aesp_ram.sv
rtl/core/aesp_datapath.sv
rtl/core/aesp_ctrl.sv
rtl/core/ansi_escape_sequence_parser_top.sv
rtl/core/aesp_checker.sv
dv/tb_top.sv
